// ===== hw/rtl/dilf_pkg.sv =====
// Shared widths, register indexes and result codes for the descriptor index free list.
package dilf_pkg;

  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned HANDLE_W   = 64;
  localparam int unsigned STRIDE_W   = 12;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned STATUS_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DESC_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_STRIDE = 3'd4;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [COUNT_W-1:0] DESC_COUNT_RESET = 7'd16;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC_OK     = 2'd0,
    ST_ALLOC_FAIL   = 2'd1,
    ST_FREE_OK      = 2'd2,
    ST_FREE_IGNORED = 2'd3
  } status_e;

endpackage

// ===== hw/rtl/dilf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dilf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/descriptor_index_free_list_top.sv =====
// Descriptor slot allocator: LIFO free list of slot indices held in a synchronous RAM.
// Allocate: stack RAM read, index*stride, base add, then the result goes to the output register.
// Free: base subtract, range check, bit-per-cycle divider over IW = clog2(MAX_DESCRIPTORS) bits, push.
// One item is in flight at a time; the next is taken once the result is in the output register.
// Reset empties the stack and loads register defaults; writing heap_enable=1 reloads the
// stack at once through a fill mark, so no clearing pass runs and the RAM is never swept.
module descriptor_index_free_list_top
  import dilf_pkg::*;
#(
  parameter int unsigned MAX_DESCRIPTORS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  req_type_i,
  input  logic [HANDLE_W-1:0]   cpu_handle_in_i,
  input  logic [HANDLE_W-1:0]   gpu_handle_in_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SLOT_W-1:0]     slot_index_o,
  output logic [HANDLE_W-1:0]   cpu_handle_out_o,
  output logic [HANDLE_W-1:0]   gpu_handle_out_o
);

  localparam int unsigned IW   = $clog2(MAX_DESCRIPTORS);
  localparam int unsigned DW   = $clog2(MAX_DESCRIPTORS + 1);
  localparam int unsigned RW   = IW + STRIDE_W;
  localparam int unsigned CW   = $clog2(IW + 1);
  localparam int unsigned LIMW = DW + STRIDE_W;
  localparam int unsigned CMPW = (DW > COUNT_W) ? DW : COUNT_W;

  localparam logic [DW-1:0]   MAX_D   = DW'(MAX_DESCRIPTORS);
  localparam logic [CMPW-1:0] MAX_CMP = CMPW'(MAX_DESCRIPTORS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALOOK,
    S_AADD,
    S_FSUB,
    S_FCHK,
    S_FDIV,
    S_FPUSH,
    S_DONE
  } state_e;

  // control state
  state_e                state_q, state_d;
  logic                  enable_q, enable_d;
  logic [COUNT_W-1:0]    count_q, count_d;
  logic [HANDLE_W-1:0]   cpu_base_q, cpu_base_d;
  logic [HANDLE_W-1:0]   gpu_base_q, gpu_base_d;
  logic [STRIDE_W-1:0]   stride_q, stride_d;
  logic [DW-1:0]         depth_q, depth_d;
  logic [DW-1:0]         low_q, low_d;      // entries below this still hold their reload value
  logic [DW-1:0]         load_n_q, load_n_d;
  logic                  out_valid_q, out_valid_d;

  // datapath
  logic [IW-1:0]         pos_q, pos_d;
  logic [HANDLE_W-1:0]   cpu_h_q, cpu_h_d;
  logic [HANDLE_W-1:0]   gpu_h_q, gpu_h_d;
  logic                  cbor_q, cbor_d;
  logic                  gbor_q, gbor_d;
  logic [RW-1:0]         crem_q, crem_d;
  logic [RW-1:0]         grem_q, grem_d;
  logic [RW-1:0]         dv_q, dv_d;
  logic [IW-1:0]         cq_q, cq_d;
  logic [IW-1:0]         gq_q, gq_d;
  logic [CW-1:0]         step_q, step_d;
  logic [RW-1:0]         prod_q, prod_d;
  logic [IW-1:0]         idx_q, idx_d;
  status_e               res_status_q, res_status_d;
  logic [IW-1:0]         res_idx_q, res_idx_d;
  logic [HANDLE_W-1:0]   res_cpu_q, res_cpu_d;
  logic [HANDLE_W-1:0]   res_gpu_q, res_gpu_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [HANDLE_W-1:0]   cpu_out_q, cpu_out_d;
  logic [HANDLE_W-1:0]   gpu_out_q, gpu_out_d;

  // stack RAM
  logic                  mem_we, mem_re;
  logic [IW-1:0]         mem_waddr, mem_raddr, mem_wdata, mem_rdata;

  logic                  in_acc, out_acc;
  logic [CMPW-1:0]       cnt_cmp;
  logic [DW-1:0]         reload_n;
  logic [LIMW-1:0]       lim;
  logic [HANDLE_W:0]     csub, gsub;
  logic                  cbit, gbit;
  logic [IW-1:0]         look_idx;

  dilf_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_DESCRIPTORS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign out_acc    = out_valid_q && !out_stall_i;

  assign mem_re    = in_acc && (req_type_i == REQ_ALLOC) && enable_q && (depth_q != '0);
  assign mem_raddr = IW'(depth_q - DW'(1));
  assign mem_we    = (state_q == S_FPUSH) && (cq_q == gq_q);
  assign mem_waddr = IW'(depth_q);
  assign mem_wdata = cq_q;

  assign cnt_cmp  = CMPW'(count_q);
  assign reload_n = (cnt_cmp > MAX_CMP) ? MAX_D : DW'(cnt_cmp);
  // every offset below MAX*stride divides to an index that fits the stack
  assign lim      = LIMW'(MAX_DESCRIPTORS) * LIMW'(stride_q);
  assign csub     = {1'b0, cpu_h_q} - {1'b0, cpu_base_q};
  assign gsub     = {1'b0, gpu_h_q} - {1'b0, gpu_base_q};
  assign cbit     = (crem_q >= dv_q);
  assign gbit     = (grem_q >= dv_q);
  // entries under the fill mark were never overwritten since reload: value is n-1-pos
  assign look_idx = (DW'(pos_q) < low_q) ? IW'(load_n_q - DW'(1) - DW'(pos_q)) : mem_rdata;

  always_comb begin
    state_d      = state_q;
    enable_d     = enable_q;
    count_d      = count_q;
    cpu_base_d   = cpu_base_q;
    gpu_base_d   = gpu_base_q;
    stride_d     = stride_q;
    depth_d      = depth_q;
    low_d        = low_q;
    load_n_d     = load_n_q;
    out_valid_d  = out_valid_q && !out_acc;
    pos_d        = pos_q;
    cpu_h_d      = cpu_h_q;
    gpu_h_d      = gpu_h_q;
    cbor_d       = cbor_q;
    gbor_d       = gbor_q;
    crem_d       = crem_q;
    grem_d       = grem_q;
    dv_d         = dv_q;
    cq_d         = cq_q;
    gq_d         = gq_q;
    step_d       = step_q;
    prod_d       = prod_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_cpu_d    = res_cpu_q;
    res_gpu_d    = res_gpu_q;
    status_d     = status_q;
    slot_d       = slot_q;
    cpu_out_d    = cpu_out_q;
    gpu_out_d    = gpu_out_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_idx_d = '0;
          res_cpu_d = '0;
          res_gpu_d = '0;
          cpu_h_d   = cpu_handle_in_i;
          gpu_h_d   = gpu_handle_in_i;
          if (req_type_i == REQ_ALLOC) begin
            if (mem_re) begin
              depth_d = depth_q - DW'(1);
              pos_d   = mem_raddr;
              state_d = S_ALOOK;
            end else begin
              res_status_d = ST_ALLOC_FAIL;
              state_d      = S_DONE;
            end
          end else begin
            if (enable_q && (stride_q != '0)) begin
              state_d = S_FSUB;
            end else begin
              res_status_d = ST_FREE_IGNORED;
              state_d      = S_DONE;
            end
          end
        end
      end
      S_ALOOK: begin
        idx_d   = look_idx;
        prod_d  = RW'(look_idx) * RW'(stride_q);
        state_d = S_AADD;
      end
      S_AADD: begin
        res_status_d = ST_ALLOC_OK;
        res_idx_d    = idx_q;
        res_cpu_d    = cpu_base_q + HANDLE_W'(prod_q);
        res_gpu_d    = gpu_base_q + HANDLE_W'(prod_q);
        state_d      = S_DONE;
      end
      S_FSUB: begin
        cpu_h_d = csub[HANDLE_W-1:0];
        gpu_h_d = gsub[HANDLE_W-1:0];
        cbor_d  = csub[HANDLE_W];
        gbor_d  = gsub[HANDLE_W];
        state_d = S_FCHK;
      end
      S_FCHK: begin
        if (!cbor_q && !gbor_q && (cpu_h_q < HANDLE_W'(lim)) && (gpu_h_q < HANDLE_W'(lim))
            && (depth_q < MAX_D)) begin
          crem_d  = RW'(cpu_h_q);
          grem_d  = RW'(gpu_h_q);
          dv_d    = RW'(stride_q) << (IW - 1);
          cq_d    = '0;
          gq_d    = '0;
          step_d  = CW'(IW - 1);
          state_d = S_FDIV;
        end else begin
          res_status_d = ST_FREE_IGNORED;
          state_d      = S_DONE;
        end
      end
      S_FDIV: begin
        // restoring division, one quotient bit per cycle for both handles
        if (cbit) crem_d = crem_q - dv_q;
        if (gbit) grem_d = grem_q - dv_q;
        cq_d = (cq_q << 1) | IW'(cbit);
        gq_d = (gq_q << 1) | IW'(gbit);
        dv_d = dv_q >> 1;
        if (step_q == '0) begin
          state_d = S_FPUSH;
        end else begin
          step_d = step_q - CW'(1);
        end
      end
      S_FPUSH: begin
        if (cq_q == gq_q) begin
          depth_d      = depth_q + DW'(1);
          low_d        = (depth_q < low_q) ? depth_q : low_q;
          res_status_d = ST_FREE_OK;
          res_idx_d    = cq_q;
        end else begin
          res_status_d = ST_FREE_IGNORED;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_acc) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          slot_d      = SLOT_W'(res_idx_q);
          cpu_out_d   = res_cpu_q;
          gpu_out_d   = res_gpu_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_HEAP_ENABLE: begin
          enable_d = cfg_wdata_i[0];
          if (cfg_wdata_i[0]) begin
            depth_d  = reload_n;
            low_d    = reload_n;
            load_n_d = reload_n;
          end
        end
        CFG_DESC_COUNT:  count_d    = cfg_wdata_i[COUNT_W-1:0];
        CFG_CPU_BASE:    cpu_base_d = cfg_wdata_i[HANDLE_W-1:0];
        CFG_GPU_BASE:    gpu_base_d = cfg_wdata_i[HANDLE_W-1:0];
        CFG_SLOT_STRIDE: stride_d   = cfg_wdata_i[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      enable_q    <= 1'b0;
      count_q     <= DESC_COUNT_RESET;
      cpu_base_q  <= '0;
      gpu_base_q  <= '0;
      stride_q    <= '0;
      depth_q     <= '0;
      low_q       <= '0;
      load_n_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      enable_q    <= enable_d;
      count_q     <= count_d;
      cpu_base_q  <= cpu_base_d;
      gpu_base_q  <= gpu_base_d;
      stride_q    <= stride_d;
      depth_q     <= depth_d;
      low_q       <= low_d;
      load_n_q    <= load_n_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    cpu_h_q      <= cpu_h_d;
    gpu_h_q      <= gpu_h_d;
    cbor_q       <= cbor_d;
    gbor_q       <= gbor_d;
    crem_q       <= crem_d;
    grem_q       <= grem_d;
    dv_q         <= dv_d;
    cq_q         <= cq_d;
    gq_q         <= gq_d;
    step_q       <= step_d;
    prod_q       <= prod_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    res_cpu_q    <= res_cpu_d;
    res_gpu_q    <= res_gpu_d;
    status_q     <= status_d;
    slot_q       <= slot_d;
    cpu_out_q    <= cpu_out_d;
    gpu_out_q    <= gpu_out_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign slot_index_o     = slot_q;
  assign cpu_handle_out_o = cpu_out_q;
  assign gpu_handle_out_o = gpu_out_q;

endmodule
